FILE: design/ewsd_pkg.sv
// Package for the exit window start detector: beat layouts, register
// indexes and fixed constants. No dependencies.
package ewsd_pkg;

    localparam int unsigned IN_TDATA_W  = 120;
    localparam int unsigned OUT_TDATA_W = 136;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_DELAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_SPEED = 2'd2;

    localparam logic [17:0] TRIGGER_SPEED_RST = 18'd10000;
    localparam logic [15:0] WINDOW_DELAY_RST  = 16'd9000;
    localparam logic [17:0] CONFIRM_SPEED_RST = 18'd30000;

    localparam logic [31:0] WEEK_MS = 32'd604800000;
    localparam logic [2:0]  FIX_3D  = 3'd3;

    // last field in the lowest bits
    typedef struct packed {
        logic [2:0]         pad;
        logic signed [20:0] down_velocity;
        logic signed [31:0] longitude;
        logic signed [30:0] latitude;
        logic [29:0]        time_of_week;
        logic [2:0]         fix_type;
    } t_in_item;

    typedef struct packed {
        logic [6:0]         pad;
        logic signed [31:0] current_longitude;
        logic signed [30:0] current_latitude;
        logic               has_current;
        logic signed [31:0] origin_longitude;
        logic signed [30:0] origin_latitude;
        logic               is_started;
        logic               window_opened;
    } t_out_item;

endpackage

FILE: design/exit_window_start_detector_unit.sv
// Exit window start detector: arms on descent, confirms on peak descent
// after a delay and latches the origin position. Depends on ewsd_pkg.
//
// An input beat passes the input register, then the result register. Throughput:
// one beat per cycle while the receiver takes results; the decision logic between
// the two registers is combinational and reads and updates the detector state per beat.
// Reset (synchronous, active low): configuration registers return to their reset
// values, detector disarmed, not started, no current position; pipeline emptied.
module exit_window_start_detector_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // fix_type[2:0], time_of_week[32:3], latitude[63:33], longitude[95:64],
    // down_velocity[116:96], zero fill[119:117]
    input  logic [ewsd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // window_opened[0], is_started[1], origin_latitude[32:2],
    // origin_longitude[64:33], has_current[65], current_latitude[96:66],
    // current_longitude[128:97], zero fill[135:129]
    output logic [ewsd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ewsd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ewsd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [17:0] r_trigger_speed;
    logic [15:0] r_window_delay;
    logic [17:0] r_confirm_speed;

    logic                r_in_vld;
    ewsd_pkg::t_in_item  r_in;
    logic                r_out_vld;
    ewsd_pkg::t_out_item r_out;
    ewsd_pkg::t_out_item n_out;

    logic               r_armed;
    logic [29:0]        r_arm_time;
    logic signed [20:0] r_peak;
    logic               r_rearm_blocked;
    logic               r_started;
    logic signed [30:0] r_start_lat;
    logic signed [31:0] r_start_lon;
    logic               r_cur_valid;
    logic signed [30:0] r_cur_lat;
    logic signed [31:0] r_cur_lon;

    logic               n_armed;
    logic [29:0]        n_arm_time;
    logic signed [20:0] n_peak;
    logic               n_rearm_blocked;
    logic               n_started;
    logic signed [30:0] n_start_lat;
    logic signed [31:0] n_start_lon;
    logic               n_cur_valid;
    logic signed [30:0] n_cur_lat;
    logic signed [31:0] n_cur_lon;
    logic               n_opened;

    logic               advance;
    logic               is_fix;
    logic signed [21:0] vdown_x;
    logic signed [21:0] trig_x;
    logic signed [21:0] confirm_x;
    logic signed [20:0] peak_upd;
    logic               ge_trig;
    logic [31:0]        elapsed_raw;
    logic [31:0]        elapsed;
    logic               delay_done;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || advance;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_speed <= ewsd_pkg::TRIGGER_SPEED_RST;
            r_window_delay  <= ewsd_pkg::WINDOW_DELAY_RST;
            r_confirm_speed <= ewsd_pkg::CONFIRM_SPEED_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ewsd_pkg::CFG_TRIGGER_SPEED: r_trigger_speed <= i_cfg_data;
                ewsd_pkg::CFG_WINDOW_DELAY:  r_window_delay  <= i_cfg_data[15:0];
                ewsd_pkg::CFG_CONFIRM_SPEED: r_confirm_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        is_fix      = (r_in.fix_type == ewsd_pkg::FIX_3D);
        vdown_x     = {r_in.down_velocity[20], r_in.down_velocity};
        trig_x      = $signed({4'b0000, r_trigger_speed});
        confirm_x   = $signed({4'b0000, r_confirm_speed});
        ge_trig     = (vdown_x >= trig_x);
        peak_upd    = (r_in.down_velocity > r_peak) ? r_in.down_velocity : r_peak;
        elapsed_raw = {2'b00, r_in.time_of_week} - {2'b00, r_arm_time};
        elapsed     = (elapsed_raw >= ewsd_pkg::WEEK_MS) ?
                      (elapsed_raw + ewsd_pkg::WEEK_MS) : elapsed_raw;
        delay_done  = (elapsed >= {16'h0000, r_window_delay});

        n_armed         = r_armed;
        n_arm_time      = r_arm_time;
        n_peak          = r_peak;
        n_rearm_blocked = r_rearm_blocked;
        n_started       = r_started;
        n_start_lat     = r_start_lat;
        n_start_lon     = r_start_lon;
        n_cur_valid     = r_cur_valid;
        n_cur_lat       = r_cur_lat;
        n_cur_lon       = r_cur_lon;
        n_opened        = 1'b0;

        if (is_fix) begin
            n_cur_valid = 1'b1;
            n_cur_lat   = r_in.latitude;
            n_cur_lon   = r_in.longitude;
            if (!r_started) begin
                if (!r_armed) begin
                    if (ge_trig && !r_rearm_blocked) begin
                        n_armed    = 1'b1;
                        n_arm_time = r_in.time_of_week;
                        n_peak     = r_in.down_velocity;
                    end else if (!ge_trig) begin
                        n_rearm_blocked = 1'b0;
                    end
                end else begin
                    n_peak = peak_upd;
                    if (delay_done) begin
                        if ($signed({peak_upd[20], peak_upd}) < confirm_x) begin
                            n_armed         = 1'b0;
                            n_peak          = '0;
                            n_rearm_blocked = 1'b1;
                        end else begin
                            n_started   = 1'b1;
                            n_start_lat = r_in.latitude;
                            n_start_lon = r_in.longitude;
                            n_opened    = 1'b1;
                        end
                    end
                end
            end
        end

        n_out                   = '0;
        n_out.window_opened     = n_opened;
        n_out.is_started        = n_started;
        n_out.origin_latitude   = n_started ? n_start_lat : '0;
        n_out.origin_longitude  = n_started ? n_start_lon : '0;
        n_out.has_current       = n_cur_valid;
        n_out.current_latitude  = n_cur_valid ? n_cur_lat : '0;
        n_out.current_longitude = n_cur_valid ? n_cur_lon : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld        <= 1'b0;
            r_out_vld       <= 1'b0;
            r_armed         <= 1'b0;
            r_rearm_blocked <= 1'b0;
            r_started       <= 1'b0;
            r_cur_valid     <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_vld       <= 1'b1;
                r_armed         <= n_armed;
                r_rearm_blocked <= n_rearm_blocked;
                r_started       <= n_started;
                r_cur_valid     <= n_cur_valid;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= ewsd_pkg::t_in_item'(s_axis_tdata);
        end
        if (advance) begin
            r_out       <= n_out;
            r_arm_time  <= n_arm_time;
            r_peak      <= n_peak;
            r_start_lat <= n_start_lat;
            r_start_lon <= n_start_lon;
            r_cur_lat   <= n_cur_lat;
            r_cur_lon   <= n_cur_lon;
        end
    end

    a_started_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("started state dropped");

    a_opened_implies_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (!r_out.window_opened || r_out.is_started))
        else $error("window opened without started");

    a_open_only_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_started) |=> !r_out.window_opened)
        else $error("window opened twice");

    a_no_arm_and_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_armed && r_rearm_blocked))
        else $error("armed while re-arming blocked");

    a_origin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.is_started) |->
            (r_out.origin_latitude == '0 && r_out.origin_longitude == '0))
        else $error("origin shown before start");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for exit_window_start_detector_unit: stream beats in, status beats out,
// checked against an in-bench arming and window model or typed row values. Depends on ewsd_pkg.
module testbench;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam logic [ewsd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [2:0] FIX_NONE      = 3'd0;
    localparam logic [2:0] FIX_2D        = 3'd2;
    localparam logic [2:0] FIX_TIME_ONLY = 3'd5;

    typedef struct {
        logic [2:0]  fix;
        logic [29:0] tow;
        int          lat;
        int          lon;
        int          vel;
        bit          typed;
        bit          has;
    } t_sample_row;

    typedef struct {
        logic [17:0] trig;
        logic [17:0] delay;
        logic [17:0] confirm;
        int          count;
        bit          opens;
        bit          poke_unused;
    } t_phase;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [ewsd_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [ewsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [ewsd_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [ewsd_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    exit_window_start_detector_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // detector model state
    logic [17:0]        trig_reg    = ewsd_pkg::TRIGGER_SPEED_RST;
    logic [15:0]        delay_reg   = ewsd_pkg::WINDOW_DELAY_RST;
    logic [17:0]        confirm_reg = ewsd_pkg::CONFIRM_SPEED_RST;
    bit                 armed;
    logic [31:0]        arm_tow;
    int                 peak_vel;
    bit                 rearm_block;
    bit                 started;
    logic signed [30:0] org_lat;
    logic signed [31:0] org_lon;
    bit                 have_pos;
    logic signed [30:0] pos_lat;
    logic signed [31:0] pos_lon;

    ewsd_pkg::t_out_item status_due[$];
    int unsigned fault_count;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned tow_run;
    int unsigned ready_run;
    int unsigned ready_mode;
    logic [15:0] ready_pat;

    t_sample_row directed_rows [20] = '{
        '{FIX_NONE,      30'h3FFFFFFF,  900000000,  1800000000,  1000000, 1'b1, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'd0,      900000000, -1800000000,        0, 1'b1, 1'b1},
        '{ewsd_pkg::FIX_3D, 30'd1000,  -900000000,  1800000000,     9999, 1'b1, 1'b1},
        '{ewsd_pkg::FIX_3D, 30'd2000,           1,          -1,    10000, 1'b1, 1'b1},
        '{FIX_TIME_ONLY, 30'd50000,           555,         777,  1000000, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'd6000,    12345678,   -87654321,    20000, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'd11000,  -12345678,    87654321, -1000000, 1'b1, 1'b1},
        '{ewsd_pkg::FIX_3D, 30'd12000,          0,           0,    50000, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'd13000,        100,         200,     9999, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'd604799000,    300,         400,    10001, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'd1000,         500,         600,    29999, 1'b0, 1'b0},
        '{FIX_2D,        30'd7500,            700,         800,  1000000, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'd7999,         900,        1000,        0, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'd8000,        1100,        1200,        0, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'd9000,        1300,        1400,       -1, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'd20000,       1500,        1600,    10000, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'd15000,       1700,        1800,        0, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'h3FFFFFFF, -1073741824, 32'h80000000, -1048576, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'h3FFFFFFF, 1073741823, 32'h7FFFFFFF,  10000, 1'b0, 1'b0},
        '{ewsd_pkg::FIX_3D, 30'd500,           -5,          -6,        0, 1'b0, 1'b0}
    };

    t_phase phases [7] = '{
        '{18'd10000,  18'd9000,    18'd30000,  300, 1'b0, 1'b0},
        '{18'd0,      18'd0,       18'h3FFFF,  400, 1'b0, 1'b0},
        '{18'd200000, 18'd60000,   18'h3FFFF,  300, 1'b0, 1'b1},
        '{18'd5000,   18'h3FFFF,   18'd150000, 300, 1'b0, 1'b0},
        '{18'h3FFFF,  18'd100,     18'd200000, 100, 1'b0, 1'b0},
        '{18'd1000,   18'd500,     18'd20000,  400, 1'b0, 1'b0},
        '{18'd20000,  18'd2000,    18'd0,      100, 1'b1, 1'b0}
    };

    function automatic ewsd_pkg::t_out_item detector_step(input ewsd_pkg::t_in_item it);
        ewsd_pkg::t_out_item r;
        logic [31:0]         elapsed;
        int                  vdown;
        r = '0;
        vdown = it.down_velocity;
        if (it.fix_type == ewsd_pkg::FIX_3D) begin
            pos_lat = it.latitude;
            pos_lon = it.longitude;
            have_pos = 1'b1;
            if (!started) begin
                if (!armed) begin
                    if (rearm_block && vdown < int'(trig_reg))
                        rearm_block = 1'b0;
                    if (vdown >= int'(trig_reg) && !rearm_block) begin
                        armed = 1'b1;
                        arm_tow = {2'b00, it.time_of_week};
                        peak_vel = vdown;
                    end
                end else begin
                    if (vdown > peak_vel)
                        peak_vel = vdown;
                    elapsed = {2'b00, it.time_of_week} - arm_tow;
                    if (elapsed >= ewsd_pkg::WEEK_MS)
                        elapsed = elapsed + ewsd_pkg::WEEK_MS;
                    if (elapsed >= {16'h0000, delay_reg}) begin
                        if (peak_vel < int'(confirm_reg)) begin
                            armed = 1'b0;
                            peak_vel = 0;
                            rearm_block = 1'b1;
                        end else begin
                            started = 1'b1;
                            org_lat = it.latitude;
                            org_lon = it.longitude;
                            r.window_opened = 1'b1;
                        end
                    end
                end
            end
        end
        r.is_started = started;
        if (started) begin
            r.origin_latitude = org_lat;
            r.origin_longitude = org_lon;
        end
        r.has_current = have_pos;
        if (have_pos) begin
            r.current_latitude = pos_lat;
            r.current_longitude = pos_lon;
        end
        return r;
    endfunction

    function automatic ewsd_pkg::t_in_item make_sample(input bit opens);
        ewsd_pkg::t_in_item it;
        logic signed [20:0] raw_vel;
        int                 vel;
        int                 trig;
        int                 conf;
        int unsigned        step;
        it = '0;
        trig = int'(trig_reg);
        conf = int'(confirm_reg);
        if ($urandom_range(0, 9) < 8)
            it.fix_type = ewsd_pkg::FIX_3D;
        else
            it.fix_type = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 39))
            0: tow_run = $urandom_range(0, 32'h3FFFFFFF);
            1: tow_run = (tow_run >= 5000) ? tow_run - $urandom_range(0, 5000) : tow_run;
            2: tow_run = ewsd_pkg::WEEK_MS - $urandom_range(1, 4000);
            default: begin
                step = $urandom_range(0, int'(delay_reg) / 3 + 300);
                if (tow_run < ewsd_pkg::WEEK_MS && tow_run + step >= ewsd_pkg::WEEK_MS)
                    tow_run = tow_run + step - ewsd_pkg::WEEK_MS;
                else
                    tow_run = (tow_run + step) & 32'h3FFFFFFF;
            end
        endcase
        it.time_of_week = 30'(tow_run);
        case ($urandom_range(0, 7))
            0: it.latitude = 31'(900000000);
            1: it.latitude = 31'(-900000000);
            default: it.latitude = 31'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: it.longitude = 1800000000;
            1: it.longitude = -1800000000;
            default: it.longitude = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0: begin
                raw_vel = 21'($urandom);
                vel = raw_vel;
            end
            1: vel = trig - int'($urandom_range(1, 3000));
            2: vel = trig;
            3: vel = 0 - int'($urandom_range(0, 1000000));
            default: vel = trig +
                int'($urandom_range(0, (conf > trig) ? conf - trig + 2000 : 5000));
        endcase
        // hold peaks under the confirm speed until the phase that may open the window
        if (!opens && it.fix_type == ewsd_pkg::FIX_3D && vel >= conf)
            vel = conf - 1 - int'($urandom_range(0, 1000));
        it.down_velocity = 21'(vel);
        return it;
    endfunction

    task automatic flag_fault(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            flag_fault($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic send_sample(input ewsd_pkg::t_in_item it, input bit typed,
                               input ewsd_pkg::t_out_item typed_val);
        int unsigned         gap;
        ewsd_pkg::t_out_item pred;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tdata <= it;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = detector_step(it);
        status_due.push_back(typed ? typed_val : pred);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [ewsd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ewsd_pkg::CFG_DATA_W-1:0] value);
        i_cfg_index <= idx;
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            ewsd_pkg::CFG_TRIGGER_SPEED: trig_reg = value;
            ewsd_pkg::CFG_WINDOW_DELAY:  delay_reg = value[15:0];
            ewsd_pkg::CFG_CONFIRM_SPEED: confirm_reg = value;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic settle(input int unsigned tail);
        s_axis_tvalid <= 1'b0;
        while (status_due.size() != 0) @(negedge i_clk);
        repeat (tail) @(negedge i_clk);
    endtask

    // receiver stalls on a rotating pattern, with stretches of steady ready
    always @(negedge i_clk) begin
        if (ready_run == 0) begin
            ready_run = $urandom_range(16, 96);
            ready_mode = $urandom_range(0, 3);
            ready_pat = 16'($urandom) | 16'h0001;
        end
        ready_run--;
        ready_pat = {ready_pat[14:0], ready_pat[15]};
        m_axis_tready <= (ready_mode == 0) || ready_pat[0];
    end

    always @(posedge i_clk) begin : result_check
        ewsd_pkg::t_out_item got;
        ewsd_pkg::t_out_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (status_due.size() == 0) begin
                flag_fault("result beat with nothing outstanding");
            end else begin
                want = status_due.pop_front();
                check_field("window_opened", got.window_opened, want.window_opened);
                check_field("is_started", got.is_started, want.is_started);
                check_field("origin_latitude", got.origin_latitude, want.origin_latitude);
                check_field("origin_longitude", got.origin_longitude, want.origin_longitude);
                check_field("has_current", got.has_current, want.has_current);
                check_field("current_latitude", got.current_latitude, want.current_latitude);
                check_field("current_longitude", got.current_longitude,
                            want.current_longitude);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        ewsd_pkg::t_in_item  it;
        ewsd_pkg::t_out_item typed_val;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            it = '0;
            it.fix_type = directed_rows[k].fix;
            it.time_of_week = directed_rows[k].tow;
            it.latitude = 31'(directed_rows[k].lat);
            it.longitude = directed_rows[k].lon;
            it.down_velocity = 21'(directed_rows[k].vel);
            typed_val = '0;
            typed_val.has_current = directed_rows[k].has;
            if (directed_rows[k].has) begin
                typed_val.current_latitude = 31'(directed_rows[k].lat);
                typed_val.current_longitude = directed_rows[k].lon;
            end
            send_sample(it, directed_rows[k].typed, typed_val);
        end
        tow_run = 0;

        foreach (phases[p]) begin
            if (p != 0) begin
                settle(4);
                write_reg(ewsd_pkg::CFG_TRIGGER_SPEED, phases[p].trig);
                write_reg(ewsd_pkg::CFG_WINDOW_DELAY, phases[p].delay);
                write_reg(ewsd_pkg::CFG_CONFIRM_SPEED, phases[p].confirm);
                if (phases[p].poke_unused)
                    write_reg(CFG_UNUSED, 18'h2AAAA);
                i_cfg_valid <= 1'b0;
            end
            repeat (phases[p].count)
                send_sample(make_sample(phases[p].opens), 1'b0, '0);
        end

        settle(8);
        if (fault_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
